// ===== design/dss_pkg.sv =====
// Shared types and constants for the differential serial addressed slave.
// Used by dss_link and the top level; no dependencies.
package dss_pkg;

  // Byte buffer geometry
  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = STORE_AW + 1;

  // Serial framing
  localparam int             ADDR_W        = 10;
  localparam logic [4:0]     START_PATTERN = 5'b11001;
  localparam logic [3:0]     START_BITS    = 4'd5;
  localparam logic [3:0]     ADDR_BITS     = 4'd10;
  localparam logic [3:0]     BYTE_BITS     = 4'd8;

  // Transaction function codes
  typedef enum logic [1:0] {
    FN_EDGE = 2'd0,
    FN_LOAD = 2'd1,
    FN_READ = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  // Link phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_ADDR  = 2'd2,
    PH_XCHG  = 2'd3
  } phase_t;

  // Buffer write request
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } wr_req_t;

  // Per-transaction result, minus the buffer read data
  typedef struct packed {
    logic             tx_pos;
    logic             tx_neg;
    logic             line_stop;
    logic             selected;
    logic             byte_done;
    logic [7:0]       rx_byte;
    logic [CNT_W-1:0] stored_count;
    logic             read_valid;
  } result_t;

endpackage

// ===== design/diff_serial_addressed_slave.sv =====
// Top level of the differential serial addressed slave.
// Depends on dss_pkg, dss_link and dss_ram.
//
// One transaction is taken per clock cycle while in_stall is low, each edge, load
// or read transaction alike. The link state updates at the accepting edge while the
// byte buffer read port is issued; the result then sits in a holding stage, then in
// the output register. The holding stage lets one more transaction in while a
// result waits on a stalled output.
// The buffer holds 1024 bytes and needs no clearing pass after reset: entries at
// or above the stored count never read out.
module diff_serial_addressed_slave (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic                         in_rx_pos,
  input  logic                         in_rx_neg,
  input  logic [7:0]                   in_tx_byte,
  input  logic [dss_pkg::STORE_AW-1:0] in_read_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_tx_pos,
  output logic                         out_tx_neg,
  output logic                         out_line_stop,
  output logic                         out_selected,
  output logic                         out_byte_done,
  output logic [7:0]                   out_rx_byte,
  output logic [dss_pkg::CNT_W-1:0]    out_stored_count,
  output logic [7:0]                   out_read_data,
  output logic                         out_read_valid,
  input  logic                         cfg_wr_en,
  input  logic [dss_pkg::ADDR_W-1:0]   cfg_wr_data
);
  import dss_pkg::*;

  logic      accept;
  wr_req_t   wr_req;
  logic      rd_en;
  result_t   link_res;
  logic [7:0] ram_q;

  logic      hold_valid_r;
  result_t   hold_res_r;
  logic      out_valid_r;
  result_t   out_res_r;
  logic [7:0] out_rdata_r;
  logic      out_free;
  logic      hold_move;

  // Handshake between the holding stage and the output register
  assign out_free  = !out_valid_r || !out_stall;
  assign hold_move = hold_valid_r && out_free;
  assign in_stall  = hold_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;

  dss_link u_link (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .func        (in_func),
    .rx_pos      (in_rx_pos),
    .rx_neg      (in_rx_neg),
    .tx_byte     (in_tx_byte),
    .read_index  (in_read_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_req      (wr_req),
    .rd_en       (rd_en),
    .result      (link_res)
  );

  dss_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (wr_req.we),
    .waddr (wr_req.addr),
    .wdata (wr_req.data),
    .re    (rd_en),
    .raddr (in_read_index),
    .rdata (ram_q)
  );

  // Holding stage: result of the accepted transaction, RAM data arrives alongside
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (hold_move) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_res_r <= link_res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hold_move || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      out_res_r   <= hold_res_r;
      out_rdata_r <= hold_res_r.read_valid ? ram_q : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_pos       = out_res_r.tx_pos;
  assign out_tx_neg       = out_res_r.tx_neg;
  assign out_line_stop    = out_res_r.line_stop;
  assign out_selected     = out_res_r.selected;
  assign out_byte_done    = out_res_r.byte_done;
  assign out_rx_byte      = out_res_r.rx_byte;
  assign out_stored_count = out_res_r.stored_count;
  assign out_read_data    = out_rdata_r;
  assign out_read_valid   = out_res_r.read_valid;

endmodule

// ===== design/dss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dss_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/dss_link.sv =====
// Serial link control: phase tracking, start/address matching, byte exchange,
// buffer fill count and own address register. Depends on dss_pkg.
module dss_link (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [1:0]                func,
  input  logic                      rx_pos,
  input  logic                      rx_neg,
  input  logic [7:0]                tx_byte,
  input  logic [dss_pkg::STORE_AW-1:0] read_index,
  input  logic                      cfg_wr_en,
  input  logic [dss_pkg::ADDR_W-1:0] cfg_wr_data,
  output dss_pkg::wr_req_t          wr_req,
  output logic                      rd_en,
  output dss_pkg::result_t          result
);
  import dss_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          bit_cnt_r, bit_cnt_nxt;
  logic [ADDR_W-1:0]   addr_sh_r, addr_sh_nxt;
  logic [7:0]          rx_sh_r, rx_sh_nxt;
  logic [7:0]          tx_hold_r, tx_hold_nxt;
  logic [1:0]          line_r, line_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [ADDR_W-1:0]   own_addr_r;

  func_t               fn;
  logic                is_edge;
  logic                stop;
  logic [2:0]          start_idx;
  logic [2:0]          tx_idx;
  logic                done;

  assign fn        = func_t'(func);
  assign is_edge   = accept && (fn == FN_EDGE);
  assign stop      = (rx_pos == rx_neg);
  assign start_idx = 3'(START_BITS - 4'd1) - bit_cnt_r[2:0];
  assign tx_idx    = 3'(BYTE_BITS - 4'd1) - bit_cnt_r[2:0];

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (is_edge) begin
      priority if (stop) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_IDLE:  phase_nxt = PH_START;
          PH_START: if (bit_cnt_r >= START_BITS) phase_nxt = PH_ADDR;
          PH_ADDR: begin
            if (bit_cnt_r >= ADDR_BITS) begin
              phase_nxt = (addr_sh_r == own_addr_r) ? PH_XCHG : PH_IDLE;
            end
          end
          PH_XCHG:  phase_nxt = PH_XCHG;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Bit datapath and buffer requests
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    addr_sh_nxt = addr_sh_r;
    rx_sh_nxt   = rx_sh_r;
    tx_hold_nxt = tx_hold_r;
    line_nxt    = line_r;
    fill_nxt    = fill_r;
    done        = 1'b0;
    wr_req.we   = 1'b0;
    wr_req.addr = fill_r[STORE_AW-1:0];
    wr_req.data = rx_sh_r;
    if (is_edge) begin
      priority if (stop) begin
        bit_cnt_nxt = '0;
      end else begin
        unique case (phase_r)
          PH_IDLE: bit_cnt_nxt = '0;
          PH_START: begin
            if (bit_cnt_r < START_BITS) begin
              bit_cnt_nxt = (rx_pos == START_PATTERN[start_idx]) ? bit_cnt_r + 4'd1 : '0;
            end else begin
              bit_cnt_nxt = '0;
            end
          end
          PH_ADDR: begin
            if (bit_cnt_r < ADDR_BITS) begin
              addr_sh_nxt = {addr_sh_r[ADDR_W-2:0], rx_pos};
              bit_cnt_nxt = bit_cnt_r + 4'd1;
            end else begin
              bit_cnt_nxt = '0;
            end
          end
          PH_XCHG: begin
            if (bit_cnt_r < BYTE_BITS) begin
              // drive one transmit bit, sample one receive bit
              line_nxt    = tx_hold_r[tx_idx] ? 2'b01 : 2'b10;
              rx_sh_nxt   = {rx_sh_r[6:0], rx_pos};
              bit_cnt_nxt = bit_cnt_r + 4'd1;
            end else begin
              // storage edge; byte dropped once the buffer is full
              done = 1'b1;
              if (fill_r < CNT_W'(STORE_DEPTH)) begin
                wr_req.we = 1'b1;
                fill_nxt  = fill_r + CNT_W'(1);
              end
              rx_sh_nxt   = '0;
              bit_cnt_nxt = '0;
            end
          end
          default: bit_cnt_nxt = '0;
        endcase
      end
    end else if (accept && (fn == FN_LOAD)) begin
      tx_hold_nxt = tx_byte;
    end
  end

  assign rd_en = accept && (fn == FN_READ);

  // Result fields reflect the state after this transaction
  always_comb begin
    result.tx_pos       = line_nxt[0];
    result.tx_neg       = line_nxt[1];
    result.line_stop    = is_edge && stop;
    result.selected     = (phase_nxt == PH_XCHG);
    result.byte_done    = done;
    result.rx_byte      = done ? rx_sh_r : 8'd0;
    result.stored_count = fill_nxt;
    result.read_valid   = rd_en && ({1'b0, read_index} < fill_r);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= '0;
      addr_sh_r <= '0;
      rx_sh_r   <= '0;
      tx_hold_r <= '0;
      line_r    <= '0;
      fill_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      addr_sh_r <= addr_sh_nxt;
      rx_sh_r   <= rx_sh_nxt;
      tx_hold_r <= tx_hold_nxt;
      line_r    <= line_nxt;
      fill_r    <= fill_nxt;
    end
  end

  // Own address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= '0;
    end else if (cfg_wr_en) begin
      own_addr_r <= cfg_wr_data;
    end
  end

endmodule
